@@ rtl/line_sensor_average_density_defines.svh @@
// Assertion macros shared by the line sensor average density RTL.
`ifndef LINE_SENSOR_AVERAGE_DENSITY_DEFINES_SVH
`define LINE_SENSOR_AVERAGE_DENSITY_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define LSAD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define LSAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lsad_pkg.sv @@
// Types and constants of the line sensor average density block.
package lsad_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DENSITY_GAIN    = 1'b1;

  // log10(2) in Q24 and the width of gain times that constant.
  localparam logic [22:0] LOG10_2_Q24 = 23'd5050445;
  localparam int unsigned GAIN_K_W    = 39;

  typedef struct packed {
    logic [1:0]  sensor;
    logic [11:0] pixel;
    logic [15:0] sample;
    logic        frame_end;
  } lsad_in_t;

  typedef struct packed {
    logic [1:0]  out_sensor;
    logic [11:0] out_pixel;
    logic [15:0] average;
    logic [15:0] density;
    logic        density_valid;
    logic        out_frame_end;
  } lsad_out_t;

endpackage

@@ rtl/line_sensor_average_density.sv @@
// Moving average and optical density of line-sensor pixels, top level.
//
//  channel  | signals                          | carries
//  ---------+----------------------------------+--------------------------------
//  input    | in_valid_i, in_ready_o, in_req_i | one pixel request per transfer
//  output   | out_valid_o, out_ready_i, out_rsp_o | average and density per pixel
//  config   | cfg_we_i, cfg_idx_i, cfg_wdata_i | register write, no read-back
//
// One pixel is taken every cycle while in_ready_o is high; the results of pixels
// with a full window leave through a two-entry output buffer. The rate is set by
// the single read-modify-write stage on the background, window sum and ring
// memories, which forwards the last write to a following request for the same entry.
// After reset a clearing pass over all 2**(SIW + PW) entries (16384 with the defaults)
// zeroes the background and window sum memories; no request is taken during it.
// The whole pipeline holds while both output buffer entries are occupied.
module line_sensor_average_density #(
  parameter int unsigned SENSORS           = 4,
  parameter int unsigned PIXELS            = 4096,
  parameter int unsigned WINDOW_FRAMES     = 8,
  parameter int unsigned BACKGROUND_FRAMES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lsad_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lsad_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  lsad_pkg::lsad_in_t                 in_req_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output lsad_pkg::lsad_out_t                out_rsp_o
);
  import lsad_pkg::*;

`include "line_sensor_average_density_defines.svh"

  localparam int unsigned SIW = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int unsigned PW  = $clog2(PIXELS);
  localparam int unsigned SLW = $clog2(WINDOW_FRAMES);
  localparam int unsigned PAW = SIW + PW;
  localparam int unsigned RAW = SIW + SLW + PW;
  localparam int unsigned BFW = $clog2(BACKGROUND_FRAMES + 1);
  localparam int unsigned WFW = $clog2(WINDOW_FRAMES + 1);

  localparam logic [BFW-1:0] BF_LAST   = BFW'(BACKGROUND_FRAMES - 1);
  localparam logic [BFW-1:0] BF_DONE   = BFW'(BACKGROUND_FRAMES);
  localparam logic [WFW-1:0] WF_DONE   = WFW'(WINDOW_FRAMES);
  localparam logic [SLW-1:0] SLOT_LAST = SLW'(WINDOW_FRAMES - 1);

  // Division by the frame counts: reciprocal product, then one correction.
  localparam logic [31:0] BG_DIV   = 32'(BACKGROUND_FRAMES);
  localparam logic [31:0] BG_RECIP = 32'(64'hFFFF_FFFF / 64'(BACKGROUND_FRAMES));
  localparam logic [31:0] WS_DIV   = 32'(WINDOW_FRAMES);
  localparam logic [31:0] WS_RECIP = 32'(64'hFFFF_FFFF / 64'(WINDOW_FRAMES));
  localparam bit          BG_POW2  = ((BACKGROUND_FRAMES & (BACKGROUND_FRAMES - 1)) == 0);
  localparam int unsigned BG_SH    = $clog2(BACKGROUND_FRAMES);

  localparam int unsigned NST   = 26;
  localparam int unsigned ST_D3 = 3;
  localparam int unsigned ST_P0 = 4;
  localparam int unsigned ST_N1 = 5;
  localparam int unsigned ST_M1 = 24;
  localparam int unsigned ST_M2 = 25;

  typedef struct packed {
    logic [1:0]  sensor;
    logic [11:0] pixel;
    logic        fe;
    logic        dv;
    logic [15:0] avg;
    logic        dz;
    logic        le;
  } ctx_t;

  // Configuration.
  logic [15:0]         ref_q;
  logic [GAIN_K_W-1:0] k_q;

  // Handshake and decode.
  logic           en, accept, in_ok, s1_wr;
  logic [SIW-1:0] s_idx;
  logic [PW-1:0]  p_idx;
  logic [PAW-1:0] pa_in;
  logic [RAW-1:0] ra_in;

  // Per-sensor frame counters.
  logic [BFW-1:0] bfd_q  [SENSORS];
  logic [WFW-1:0] wfd_q  [SENSORS];
  logic [SLW-1:0] slot_q [SENSORS];
  logic [BFW-1:0] cur_bfd;
  logic [WFW-1:0] cur_wfd;
  logic [SLW-1:0] cur_slot;

  // Clearing pass.
  logic           clr_busy_q;
  logic [PAW-1:0] clr_addr_q;

  // Memories and their read data.
  logic [31:0] bg_mem [2**PAW];
  logic [31:0] ws_mem [2**PAW];
  logic [15:0] rg_mem [2**RAW];
  logic [31:0] bg_rd_q, ws_rd_q;
  logic [15:0] rg_rd_q;

  // Forwarding of the last write to each memory.
  logic           bfw_v_q, wfw_v_q, rfw_v_q;
  logic [PAW-1:0] bfw_a_q, wfw_a_q;
  logic [RAW-1:0] rfw_a_q;
  logic [31:0]    bfw_d_q, wfw_d_q;
  logic [15:0]    rfw_d_q;

  // Read-modify-write stage.
  logic [15:0]    s1_x_q;
  logic [PAW-1:0] s1_pa_q;
  logic [RAW-1:0] s1_ra_q;
  logic           s1_bgacc_q, s1_bglast_q, s1_wfull_q;
  logic [31:0]    bg_old, ws_old, bg_new, ws_new, bg_wr, bg_val, bg_q0, bg_quo;
  logic [63:0]    bg_prod;
  logic [15:0]    rg_old;

  // Pipeline control line.
  logic v_q   [NST];
  ctx_t ctx_q [NST];
  ctx_t ctx_d [NST];

  // Background delay and division of the window sum.
  logic [31:0] bgd_q [3];
  logic [31:0] dx1_q, dx2_q, dq0_q, dqc_q, dq_q;
  logic [63:0] dp_q;

  // Density.
  logic [31:0] p0_n_q, p0_d_q;
  logic [31:0] lx [2];
  logic [31:0] xs_d [2], n1_xs_q [2];
  logic [1:0]  hi_d [2], n1_hi_q [2];
  logic [31:0] m_d [17][2], m_q [17][2];
  logic [4:0]  e_d [17][2], e_q [17][2];
  logic [15:0] f_d [17][2], f_q [17][2];
  logic [21:0] ldiff;
  logic [20:0] l_q;
  logic        l_pos_q, m1_pos_q;
  logic [40:0] m1_pl_q, msum;
  logic [39:0] m1_ph_q;
  logic [20:0] mval;
  logic [15:0] dens_sat, dens_sel, m2_dens_q;

  // Output buffer.
  lsad_out_t fifo_q [2];
  lsad_out_t push_item;
  logic      wp_q, rp_q, push, pop;
  logic [1:0] cnt_q;

  // ---------------------------------------------------------------- decode
  assign en         = (cnt_q != 2'd2);
  assign in_ready_o = en && !clr_busy_q;
  assign accept     = in_valid_i && in_ready_o;
  assign in_ok      = (32'(in_req_i.sensor) < SENSORS) && (32'(in_req_i.pixel) < PIXELS);
  assign s_idx      = SIW'(in_req_i.sensor);
  assign p_idx      = PW'(in_req_i.pixel);
  assign cur_bfd    = bfd_q[s_idx];
  assign cur_wfd    = wfd_q[s_idx];
  assign cur_slot   = slot_q[s_idx];
  assign pa_in      = {s_idx, p_idx};
  assign ra_in      = {s_idx, cur_slot, p_idx};
  assign s1_wr      = en && v_q[0];

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= 16'd1;
      k_q   <= GAIN_K_W'(LOG10_2_Q24);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_REFERENCE_SCALE: ref_q <= cfg_wdata_i;
        REG_DENSITY_GAIN:    k_q   <= GAIN_K_W'(cfg_wdata_i) * GAIN_K_W'(LOG10_2_Q24);
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- frame counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SENSORS; i++) begin
        bfd_q[i]  <= '0;
        wfd_q[i]  <= '0;
        slot_q[i] <= '0;
      end
    end else if (accept && in_ok && in_req_i.frame_end) begin
      if (cur_bfd != BF_DONE) bfd_q[s_idx] <= cur_bfd + 1'b1;
      if (cur_wfd != WF_DONE) wfd_q[s_idx] <= cur_wfd + 1'b1;
      slot_q[s_idx] <= (cur_slot == SLOT_LAST) ? '0 : cur_slot + 1'b1;
    end
  end

  // ------------------------------------------------------ clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (&clr_addr_q) clr_busy_q <= 1'b0;
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // ------------------------------------------------------------ memories
  always_ff @(posedge clk_i) begin
    if (accept) bg_rd_q <= bg_mem[pa_in];
    if (clr_busy_q) bg_mem[clr_addr_q] <= '0;
    else if (s1_wr && s1_bgacc_q) bg_mem[s1_pa_q] <= bg_wr;
  end

  always_ff @(posedge clk_i) begin
    if (accept) ws_rd_q <= ws_mem[pa_in];
    if (clr_busy_q) ws_mem[clr_addr_q] <= '0;
    else if (s1_wr) ws_mem[s1_pa_q] <= ws_new;
  end

  always_ff @(posedge clk_i) begin
    if (accept) rg_rd_q <= rg_mem[ra_in];
    if (s1_wr) rg_mem[s1_ra_q] <= s1_x_q;
  end

  // ------------------------------------------------ read-modify-write
  // A request read in the same cycle as the write ahead of it sees stale
  // data, so the last write of each memory is kept and matched by address.
  always_comb begin
    bg_old  = (bfw_v_q && (bfw_a_q == s1_pa_q)) ? bfw_d_q : bg_rd_q;
    ws_old  = (wfw_v_q && (wfw_a_q == s1_pa_q)) ? wfw_d_q : ws_rd_q;
    rg_old  = (rfw_v_q && (rfw_a_q == s1_ra_q)) ? rfw_d_q : rg_rd_q;
    bg_new  = bg_old + 32'(s1_x_q);
    // In the last background frame the entry is replaced by its mean.
    bg_prod = 64'(bg_new) * 64'(BG_RECIP);
    bg_q0   = bg_prod[63:32];
    bg_quo  = ((bg_new - bg_q0 * BG_DIV) >= BG_DIV) ? bg_q0 + 32'd1 : bg_q0;
    if (!s1_bglast_q) bg_wr = bg_new;
    else if (BG_POW2) bg_wr = bg_new >> BG_SH;
    else bg_wr = bg_quo;
    bg_val  = s1_bgacc_q ? bg_wr : bg_old;
    ws_new  = s1_wfull_q ? (ws_old - 32'(rg_old) + 32'(s1_x_q)) : (ws_old + 32'(s1_x_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bfw_v_q <= 1'b0;
      wfw_v_q <= 1'b0;
      rfw_v_q <= 1'b0;
    end else if (s1_wr) begin
      if (s1_bgacc_q) bfw_v_q <= 1'b1;
      wfw_v_q <= 1'b1;
      rfw_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_wr) begin
      if (s1_bgacc_q) begin
        bfw_a_q <= s1_pa_q;
        bfw_d_q <= bg_wr;
      end
      wfw_a_q <= s1_pa_q;
      wfw_d_q <= ws_new;
      rfw_a_q <= s1_ra_q;
      rfw_d_q <= s1_x_q;
    end
  end

  // ------------------------------------------------------ control line
  always_comb begin
    ctx_d[0] = ctx_q[0];
    for (int k = 1; k < NST; k++) ctx_d[k] = ctx_q[k-1];
    ctx_d[ST_P0].avg = dq_q[15:0];
    ctx_d[ST_N1].dz  = (p0_d_q == '0);
    ctx_d[ST_N1].le  = (p0_n_q <= p0_d_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) v_q[k] <= 1'b0;
    end else if (en) begin
      v_q[0] <= accept && in_ok;
      // Only requests with a full window go on past the memory stage.
      v_q[1] <= v_q[0] && s1_wfull_q;
      for (int k = 2; k < NST; k++) v_q[k] <= v_q[k-1];
    end
  end

  // ------------------------------------------------------ normalisation
  assign lx[0] = p0_n_q;
  assign lx[1] = p0_d_q;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (lx[i][31:24] != '0) begin
        hi_d[i] = 2'd3;
        xs_d[i] = lx[i];
      end else if (lx[i][23:16] != '0) begin
        hi_d[i] = 2'd2;
        xs_d[i] = lx[i] << 8;
      end else if (lx[i][15:8] != '0) begin
        hi_d[i] = 2'd1;
        xs_d[i] = lx[i] << 16;
      end else begin
        hi_d[i] = 2'd0;
        xs_d[i] = lx[i] << 24;
      end
    end
  end

  // ------------------------------------------ log2 by repeated squaring
  always_comb begin
    logic [2:0]  lz;
    logic [63:0] sq;
    logic [32:0] m2;
    for (int i = 0; i < 2; i++) begin
      lz = 3'd7;
      for (int b = 0; b < 8; b++) begin
        if (n1_xs_q[i][24+b]) lz = 3'(7 - b);
      end
      m_d[0][i] = n1_xs_q[i] << lz;
      e_d[0][i] = {n1_hi_q[i], 3'd7 - lz};
      f_d[0][i] = '0;
    end
    for (int k = 1; k < 17; k++) begin
      for (int i = 0; i < 2; i++) begin
        sq = 64'(m_q[k-1][i]) * 64'(m_q[k-1][i]);
        m2 = sq[63:31];
        // A square of 2.0 or more gives a one bit and is halved.
        m_d[k][i] = m2[32] ? m2[32:1] : m2[31:0];
        e_d[k][i] = e_q[k-1][i];
        f_d[k][i] = {f_q[k-1][i][14:0], m2[32]};
      end
    end
  end

  // ------------------------------------------------------ final scaling
  always_comb begin
    ldiff    = {1'b0, e_q[16][0], f_q[16][0]} - {1'b0, e_q[16][1], f_q[16][1]};
    msum     = 41'(m1_ph_q) + 41'(m1_pl_q[40:20]);
    mval     = msum[40:20];
    dens_sat = (mval > 21'd65535) ? 16'hFFFF : mval[15:0];
    if (!ctx_q[ST_M1].dv) dens_sel = '0;
    else if (ctx_q[ST_M1].dz) dens_sel = 16'hFFFF;
    else if (ctx_q[ST_M1].le || !m1_pos_q) dens_sel = '0;
    else dens_sel = dens_sat;
  end

  // ---------------------------------------------------- pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (accept) begin
        s1_x_q      <= in_req_i.sample;
        s1_pa_q     <= pa_in;
        s1_ra_q     <= ra_in;
        s1_bgacc_q  <= (cur_bfd < BF_DONE);
        s1_bglast_q <= (cur_bfd == BF_LAST);
        s1_wfull_q  <= (cur_wfd == WF_DONE);
        ctx_q[0]    <= '{sensor: in_req_i.sensor, pixel: in_req_i.pixel,
                         fe: in_req_i.frame_end, dv: (cur_bfd >= BF_LAST),
                         avg: '0, dz: 1'b0, le: 1'b0};
      end
      for (int k = 1; k < NST; k++) ctx_q[k] <= ctx_d[k];
      // The background waits while the window sum is divided.
      bgd_q[0] <= bg_val;
      bgd_q[1] <= bgd_q[0];
      bgd_q[2] <= bgd_q[1];
      dx1_q    <= ws_new;
      dp_q     <= 64'(ws_new) * 64'(WS_RECIP);
      dx2_q    <= dx1_q;
      dq0_q    <= dp_q[63:32];
      dqc_q    <= dp_q[63:32] * WS_DIV;
      dq_q     <= ((dx2_q - dqc_q) >= WS_DIV) ? dq0_q + 32'd1 : dq0_q;
      p0_n_q <= bgd_q[2] * 32'(ref_q);
      p0_d_q <= dq_q;
      for (int i = 0; i < 2; i++) begin
        n1_xs_q[i] <= xs_d[i];
        n1_hi_q[i] <= hi_d[i];
      end
      for (int k = 0; k < 17; k++) begin
        for (int i = 0; i < 2; i++) begin
          m_q[k][i] <= m_d[k][i];
          e_q[k][i] <= e_d[k][i];
          f_q[k][i] <= f_d[k][i];
        end
      end
      l_q       <= ldiff[20:0];
      l_pos_q   <= !ldiff[21] && (ldiff != '0);
      m1_pl_q   <= 41'(l_q) * 41'(k_q[19:0]);
      m1_ph_q   <= 40'(l_q) * 40'(k_q[38:20]);
      m1_pos_q  <= l_pos_q;
      m2_dens_q <= dens_sel;
    end
  end

  // ------------------------------------------------------ output buffer
  assign push = en && v_q[NST-1];
  assign pop  = out_valid_o && out_ready_i;

  assign push_item = '{out_sensor: ctx_q[ST_M2].sensor, out_pixel: ctx_q[ST_M2].pixel,
                       average: ctx_q[ST_M2].avg, density: m2_dens_q,
                       density_valid: ctx_q[ST_M2].dv, out_frame_end: ctx_q[ST_M2].fe};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= push_item;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_rsp_o   = fifo_q[rp_q];

  // --------------------------------------------------------- assertions
  `LSAD_ASSERT_NOW(a_clear_empty, clr_busy_q, !v_q[0], "request in flight during clearing")
  `LSAD_ASSERT_NEXT(a_accept_enters, accept && in_ok, v_q[0], "accepted pixel lost")
  `LSAD_ASSERT_NOW(a_density_zero, out_valid_o && !out_rsp_o.density_valid,
                   out_rsp_o.density == 16'd0, "density set without background")

endmodule
